@@ rtl/mwr_pkg.sv @@
package mwr_pkg;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_RX    = 2'd1,
		MODE_TICK  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	localparam logic        KIND_TX        = 1'b0;
	localparam logic        KIND_STATUS    = 1'b1;
	localparam logic [7:0]  FUNC_WRITE_REG = 8'h06;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [2:0]  LAST_CMP_IDX   = 3'd5;
	localparam logic [2:0]  LAST_BYTE_IDX  = 3'd7;
	localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;
	localparam logic [15:0] REG_ADDR_RESET = 16'd194;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;
	localparam logic [7:0]  CFG_REG_ADDR   = 8'd0;
	localparam logic [7:0]  CFG_TIMEOUT    = 8'd1;

	// One queue entry: either a whole frame to send or a status word.
	typedef struct packed {
		logic        is_status;
		status_t     status;
		logic [7:0]  station;
		logic [7:0]  command;
		logic [15:0] reg_addr;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/mwr_front.sv @@
module mwr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [1:0]     mode,
	input  logic [7:0]     station_addr,
	input  logic [7:0]     command_code,
	input  logic [7:0]     rx_byte,
	input  logic [15:0]    reg_addr,
	input  logic [15:0]    timeout_ms,
	output logic           cmd_push,
	output mwr_pkg::cmd_t  cmd
);

	logic [7:0]  sent_frame_q [0:5];
	logic        busy_q;
	logic [2:0]  count_q;
	logic        mismatch_q;
	logic [15:0] elapsed_q;

	mwr_pkg::mode_t mode_e;
	logic [7:0]     expect_byte;
	logic           mis_next;
	logic [15:0]    el_next;
	logic           do_start;
	logic           do_rx;
	logic           do_tick;
	logic           rx_done;
	logic           tick_done;

	assign mode_e    = mwr_pkg::mode_t'(mode);
	assign do_start  = accept && (mode_e == mwr_pkg::MODE_START) && !busy_q;
	assign do_rx     = accept && (mode_e == mwr_pkg::MODE_RX) && busy_q;
	assign do_tick   = accept && (mode_e == mwr_pkg::MODE_TICK) && busy_q;

	always_comb begin
		expect_byte = 8'h00;
		if (count_q <= mwr_pkg::LAST_CMP_IDX) begin
			expect_byte = sent_frame_q[count_q];
		end
	end

	// Only the first six echoed bytes are compared; the CRC bytes are just counted.
	assign mis_next  = mismatch_q ||
	                   ((count_q <= mwr_pkg::LAST_CMP_IDX) && (rx_byte != expect_byte));
	assign rx_done   = do_rx && (count_q == mwr_pkg::LAST_BYTE_IDX);
	assign el_next   = (elapsed_q != mwr_pkg::ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign tick_done = do_tick && (el_next >= timeout_ms);

	always_comb begin
		cmd_push      = do_start || rx_done || tick_done;
		cmd.is_status = !do_start;
		cmd.status    = tick_done ? mwr_pkg::ST_TIMEOUT :
		                (mis_next ? mwr_pkg::ST_MISMATCH : mwr_pkg::ST_OK);
		cmd.station   = station_addr;
		cmd.command   = command_code;
		cmd.reg_addr  = reg_addr;
	end

	always_ff @(posedge clk) begin
		if (do_start) begin
			sent_frame_q[0] <= station_addr;
			sent_frame_q[1] <= mwr_pkg::FUNC_WRITE_REG;
			sent_frame_q[2] <= reg_addr[15:8];
			sent_frame_q[3] <= reg_addr[7:0];
			sent_frame_q[4] <= 8'h00;
			sent_frame_q[5] <= command_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			count_q    <= 3'd0;
			mismatch_q <= 1'b0;
			elapsed_q  <= 16'd0;
		end else if (do_start) begin
			busy_q     <= 1'b1;
			count_q    <= 3'd0;
			mismatch_q <= 1'b0;
			elapsed_q  <= 16'd0;
		end else if (do_rx) begin
			mismatch_q <= mis_next;
			if (rx_done) begin
				busy_q  <= 1'b0;
				count_q <= 3'd0;
			end else begin
				count_q <= count_q + 3'd1;
			end
		end else if (do_tick) begin
			elapsed_q <= el_next;
			if (tick_done) begin
				busy_q  <= 1'b0;
				count_q <= 3'd0;
			end
		end
	end

endmodule

@@ rtl/mwr_cmdq.sv @@
module mwr_cmdq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  mwr_pkg::cmd_t  wr_data,
	output logic           full,
	input  logic           rd_en,
	output mwr_pkg::cmd_t  rd_data,
	output logic           empty
);

	mwr_pkg::cmd_t entry_q [0:1];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

@@ rtl/mwr_back.sv @@
module mwr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  mwr_pkg::cmd_t  head,
	output logic           deq,
	input  logic           pop,
	output logic           empty,
	output logic           kind,
	output logic [7:0]     tx_byte,
	output logic           last,
	output logic [1:0]     status
);

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_q;
	logic        last_q;
	logic [1:0]  status_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;

	logic        load_en;
	logic [7:0]  frame_byte;
	logic [15:0] crc_cur;
	logic [15:0] crc_next;

	// The output register refills in the same cycle its word is taken, if the queue holds an entry.
	assign load_en = head_valid && (!out_valid_q || pop);
	assign crc_cur = (idx_q == 3'd0) ? mwr_pkg::CRC_INIT : crc_q;

	always_comb begin
		case (idx_q)
			3'd0:    frame_byte = head.station;
			3'd1:    frame_byte = mwr_pkg::FUNC_WRITE_REG;
			3'd2:    frame_byte = head.reg_addr[15:8];
			3'd3:    frame_byte = head.reg_addr[7:0];
			3'd4:    frame_byte = 8'h00;
			3'd5:    frame_byte = head.command;
			3'd6:    frame_byte = crc_q[7:0];
			default: frame_byte = crc_q[15:8];
		endcase
	end

	assign crc_next = mwr_pkg::crc_byte(crc_cur, frame_byte);
	assign deq      = load_en && (head.is_status || (idx_q == mwr_pkg::LAST_BYTE_IDX));

	always_ff @(posedge clk) begin
		if (load_en) begin
			if (head.is_status) begin
				kind_q   <= mwr_pkg::KIND_STATUS;
				tx_q     <= 8'h00;
				last_q   <= 1'b0;
				status_q <= head.status;
			end else begin
				kind_q   <= mwr_pkg::KIND_TX;
				tx_q     <= frame_byte;
				last_q   <= (idx_q == mwr_pkg::LAST_BYTE_IDX);
				status_q <= mwr_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
			crc_q       <= mwr_pkg::CRC_INIT;
		end else begin
			if (load_en) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load_en && !head.is_status) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q <= mwr_pkg::LAST_CMP_IDX) begin
					crc_q <= crc_next;
				end
			end
		end
	end

	assign empty   = !out_valid_q;
	assign kind    = kind_q;
	assign tx_byte = tx_q;
	assign last    = last_q;
	assign status  = status_q;

endmodule

@@ rtl/modbus_write_register_master_core.sv @@
// An accepted word is written into the command queue; its first result word is then loaded
// from the queue head into the output register once that register is free.
// Throughput: one input word per cycle while the two-entry command queue has room.
// A start expands into eight transmit words, sent one per cycle by the back end while the
// receiver keeps popping, with the CRC accumulated byte by byte as the frame goes out.
// Reset clears the exchange state, command queue and output register, loads the registers
// with 194 and 5000; the stored request bytes are not cleared.
module modbus_write_register_master_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  mode,
	input  logic [7:0]  station_addr,
	input  logic [7:0]  command_code,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0]   reg_addr_q;
	logic [15:0]   timeout_q;
	logic          accept;
	logic          q_full;
	logic          q_empty;
	logic          cmd_push;
	logic          deq;
	mwr_pkg::cmd_t cmd;
	mwr_pkg::cmd_t head;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign accept    = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_addr_q <= mwr_pkg::REG_ADDR_RESET;
			timeout_q  <= mwr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == mwr_pkg::CFG_REG_ADDR) begin
				reg_addr_q <= cfg_data;
			end else if (cfg_index == mwr_pkg::CFG_TIMEOUT) begin
				timeout_q <= cfg_data;
			end
		end
	end

	mwr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode),
		.station_addr (station_addr),
		.command_code (command_code),
		.rx_byte      (rx_byte),
		.reg_addr     (reg_addr_q),
		.timeout_ms   (timeout_q),
		.cmd_push     (cmd_push),
		.cmd          (cmd)
	);

	mwr_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.full    (q_full),
		.rd_en   (deq),
		.rd_data (head),
		.empty   (q_empty)
	);

	mwr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head),
		.deq        (deq),
		.pop        (pop),
		.empty      (empty),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.last       (last),
		.status     (status)
	);

endmodule

@@ bench/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int LATENCY_SLACK = 8;
	localparam int HOLD_CYCLES   = 300;

	typedef logic [7:0] frame_t [8];

	typedef struct {
		logic             kind;
		logic [7:0]       tx_byte;
		logic             last;
		mwr_pkg::status_t status;
	} word_t;

	// Tracks one write-register exchange at a time and queues the words it should emit.
	class exchange_scoreboard;
		logic [15:0] addr_reg;
		logic [15:0] timeout_reg;
		logic [7:0]  request_bytes [6];
		bit          in_exchange;
		logic [2:0]  echo_count;
		bit          echo_bad;
		logic [15:0] ms_count;
		word_t       pending_words [$];
		int          errors;

		function new();
			addr_reg    = mwr_pkg::REG_ADDR_RESET;
			timeout_reg = mwr_pkg::TIMEOUT_RESET;
			foreach (request_bytes[i]) request_bytes[i] = 8'h00;
			in_exchange = 1'b0;
			echo_count  = 3'd0;
			echo_bad    = 1'b0;
			ms_count    = 16'd0;
			errors      = 0;
		endfunction

		function void build_frame(input logic [7:0] stn, input logic [7:0] cmd,
				output frame_t f);
			logic [15:0] crc;
			f[0] = stn;
			f[1] = mwr_pkg::FUNC_WRITE_REG;
			f[2] = addr_reg[15:8];
			f[3] = addr_reg[7:0];
			f[4] = 8'h00;
			f[5] = cmd;
			crc = mwr_pkg::CRC_INIT;
			for (int i = 0; i < 6; i++) begin
				crc = crc ^ {8'h00, f[i]};
				for (int b = 0; b < 8; b++) begin
					crc = crc[0] ? ((crc >> 1) ^ mwr_pkg::CRC_POLY) : (crc >> 1);
				end
			end
			f[6] = crc[7:0];
			f[7] = crc[15:8];
		endfunction

		function void expect_word(logic k, logic [7:0] tx, logic lst, mwr_pkg::status_t st);
			word_t w;
			w.kind    = k;
			w.tx_byte = tx;
			w.last    = lst;
			w.status  = st;
			pending_words.push_back(w);
		endfunction

		function void finish_exchange(mwr_pkg::status_t st);
			expect_word(mwr_pkg::KIND_STATUS, 8'h00, 1'b0, st);
			in_exchange = 1'b0;
			echo_count  = 3'd0;
		endfunction

		function void note_word(mwr_pkg::mode_t m, logic [7:0] stn, logic [7:0] cmd,
				logic [7:0] rxb);
			frame_t f;
			case (m)
				mwr_pkg::MODE_START: begin
					if (!in_exchange) begin
						build_frame(stn, cmd, f);
						for (int i = 0; i < 6; i++) request_bytes[i] = f[i];
						for (int i = 0; i < 8; i++) begin
							expect_word(mwr_pkg::KIND_TX, f[i], i == 7, mwr_pkg::ST_OK);
						end
						in_exchange = 1'b1;
						echo_count  = 3'd0;
						echo_bad    = 1'b0;
						ms_count    = 16'd0;
					end
				end
				mwr_pkg::MODE_RX: begin
					if (in_exchange) begin
						if (echo_count <= mwr_pkg::LAST_CMP_IDX &&
								rxb != request_bytes[echo_count]) begin
							echo_bad = 1'b1;
						end
						if (echo_count == mwr_pkg::LAST_BYTE_IDX) begin
							finish_exchange(echo_bad ? mwr_pkg::ST_MISMATCH : mwr_pkg::ST_OK);
						end else begin
							echo_count = echo_count + 3'd1;
						end
					end
				end
				mwr_pkg::MODE_TICK: begin
					if (in_exchange) begin
						if (ms_count != mwr_pkg::ELAPSED_MAX) ms_count = ms_count + 16'd1;
						if (ms_count >= timeout_reg) finish_exchange(mwr_pkg::ST_TIMEOUT);
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_word(logic k, logic [7:0] tx, logic lst, mwr_pkg::status_t st);
			word_t w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word kind=%0d tx_byte=%02h last=%0d status=%0d",
					$time, k, tx, lst, st);
				errors++;
			end else begin
				w = pending_words.pop_front();
				if (w.kind !== k || w.tx_byte !== tx || w.last !== lst || w.status !== st) begin
					$display("%0t: mismatch: expected kind=%0d tx_byte=%02h last=%0d status=%0d,",
						$time, w.kind, w.tx_byte, w.last, w.status,
						" got kind=%0d tx_byte=%02h last=%0d status=%0d",
						k, tx, lst, st);
					errors++;
				end
			end
		endfunction

		function int pending();
			return pending_words.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  mode = mwr_pkg::MODE_NONE;
	logic [7:0]  station_addr = 8'h00;
	logic [7:0]  command_code = 8'h00;
	logic [7:0]  rx_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = mwr_pkg::CFG_REG_ADDR;
	logic [15:0] cfg_data = 16'h0000;

	exchange_scoreboard sb = new();

	int send_idle = 0;
	int recv_stall = 0;
	int hold_reqs = 0;
	int hold_served = 0;
	int hold_left = 0;

	modbus_write_register_master_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.mode(mode),
		.station_addr(station_addr),
		.command_code(command_code),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.tx_byte(tx_byte),
		.last(last),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	initial begin
		#8_000_000;
		$display("simulation failed");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (hold_served != hold_reqs) begin
			hold_served = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) sb.check_word(kind, tx_byte, last, mwr_pkg::status_t'(status));
			if (push && !full) begin
				sb.note_word(mwr_pkg::mode_t'(mode), station_addr, command_code, rx_byte);
			end
		end
	end

	task automatic send_item(input mwr_pkg::mode_t m, input logic [7:0] stn,
			input logic [7:0] cmd, input logic [7:0] rxb);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		station_addr <= stn;
		command_code <= cmd;
		rx_byte <= rxb;
		do @(posedge clk); while (full);
	endtask

	task automatic send_noise(inout int count);
		send_item(mwr_pkg::mode_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
			8'($urandom));
		count++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] addr, input logic [15:0] tmo);
		cfg_valid <= 1'b1;
		cfg_index <= mwr_pkg::CFG_REG_ADDR;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		sb.addr_reg = addr;
		cfg_index <= mwr_pkg::CFG_TIMEOUT;
		cfg_data <= tmo;
		do @(posedge clk); while (!cfg_ready);
		sb.timeout_reg = tmo;
		cfg_valid <= 1'b0;
	endtask

	// Mostly a start followed by the echo; some echo bytes are corrupted, ticks and
	// noise words are mixed in, and now and then the echo is cut short.
	task automatic run_exchange(inout int count);
		logic [7:0] stn;
		logic [7:0] cmd;
		frame_t     frm;
		int         nbytes;
		stn = 8'($urandom);
		cmd = 8'($urandom);
		sb.build_frame(stn, cmd, frm);
		nbytes = ($urandom_range(19) == 0) ? $urandom_range(7) : 8;
		if ($urandom_range(9) == 0) send_noise(count);
		send_item(mwr_pkg::MODE_START, stn, cmd, 8'($urandom));
		count++;
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(6) == 0) begin
				send_item(mwr_pkg::MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
				count++;
			end
			if ($urandom_range(19) == 0) send_noise(count);
			send_item(mwr_pkg::MODE_RX, 8'($urandom), 8'($urandom),
				($urandom_range(11) == 0) ? 8'($urandom) : frm[i]);
			count++;
		end
	endtask

	task automatic run_phase(input logic [15:0] addr, input logic [15:0] tmo,
			input int sidle, input int rstall, input int nitems, input bit hold);
		int  count;
		bit  paused;
		count = 0;
		paused = 1'b0;
		wait_drained();
		configure(addr, tmo);
		send_idle = sidle;
		recv_stall = rstall;
		if (hold) hold_reqs++;
		while (count < nitems) begin
			run_exchange(count);
			if (!paused && count >= nitems / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	task automatic run_directed();
		frame_t frm;
		send_item(mwr_pkg::MODE_TICK, 8'hFF, 8'hFF, 8'hFF);
		send_item(mwr_pkg::MODE_RX, 8'h00, 8'h00, 8'h00);
		send_item(mwr_pkg::MODE_NONE, 8'hFF, 8'h00, 8'hFF);
		// Echo bytes seven and eight are inverted; they are never compared.
		sb.build_frame(8'h00, 8'h00, frm);
		send_item(mwr_pkg::MODE_START, 8'h00, 8'h00, 8'h00);
		send_item(mwr_pkg::MODE_START, 8'hFF, 8'hFF, 8'hFF);
		send_item(mwr_pkg::MODE_NONE, 8'h00, 8'hFF, 8'h00);
		send_item(mwr_pkg::MODE_TICK, 8'h00, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++) begin
			send_item(mwr_pkg::MODE_RX, 8'h00, 8'h00, (i >= 6) ? ~frm[i] : frm[i]);
		end
		// A bad sixth byte, the last one compared.
		sb.build_frame(8'hFF, 8'hFF, frm);
		send_item(mwr_pkg::MODE_START, 8'hFF, 8'hFF, 8'h00);
		for (int i = 0; i < 8; i++) begin
			send_item(mwr_pkg::MODE_RX, 8'hFF, 8'hFF, (i == 5) ? ~frm[i] : frm[i]);
		end
		// With a zero timeout the first tick ends the exchange.
		wait_drained();
		configure(mwr_pkg::REG_ADDR_RESET, 16'd0);
		send_item(mwr_pkg::MODE_START, 8'h5A, 8'hA5, 8'h00);
		send_item(mwr_pkg::MODE_TICK, 8'h00, 8'h00, 8'h00);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_phase(16'h0000, 16'd1, 0, 0, 80, 1'b1);
		run_phase(16'hFFFF, 16'hFFFF, 67, 0, 80, 1'b0);
		run_phase(16'($urandom), 16'd3, 0, 67, 80, 1'b0);
		run_phase(16'($urandom), mwr_pkg::TIMEOUT_RESET, 11, 11, 80, 1'b0);
		run_phase(16'($urandom), 16'($urandom_range(12, 2)), 0, 0, 80, 1'b1);
		wait_drained();
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/mwr_pkg.sv
rtl/mwr_front.sv
rtl/mwr_cmdq.sv
rtl/mwr_back.sv
rtl/modbus_write_register_master_core.sv
bench/testbench.sv
